// File: hdl/etd_pkg.sv
// Shared types, register codes and constant-divider helpers for the echo distance display.
`default_nettype none
package etd_pkg;

	localparam int unsigned APB_ADDR_W = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_ALARM    = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic [15:0] ALARM_RESET    = 16'd475;
	localparam logic [15:0] INTERVAL_RESET = 16'd500;

	localparam logic ACTION_TICK   = 1'b0;
	localparam logic ACTION_TOGGLE = 1'b1;

	// Reciprocals for exact division by constants over the value ranges used here.
	localparam logic [22:0] Q500_MUL  = 23'd4294968;   // ceil(2^29 / 125), on y >> 2
	localparam logic [27:0] MM_MUL    = 28'd214748365; // ceil(2^30 / 5), on w >> 1
	localparam logic [27:0] INCH_MUL  = 28'd135274561; // ceil(2^34 / 127), on w >> 1
	localparam logic [23:0] DIV10_MUL = 24'd13421773;  // ceil(2^26 / 5), on v >> 1
	localparam logic [18:0] DIV12_MUL = 19'd349526;    // ceil(2^20 / 3), on v >> 2

	typedef struct packed {
		logic [15:0] alarm_threshold_mm;
		logic [15:0] trigger_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic disp;
		logic inch;
	} ctl_t;

	typedef struct packed {
		logic        start;
		logic        disp;
		logic        inch;
		logic        buzz;
		logic [23:0] val;
		logic [3:0]  d0;
		logic [3:0]  d1;
		logic [3:0]  d2;
		logic [3:0]  d3;
	} dig_t;

	function automatic logic [23:0] div10(input logic [23:0] v);
		logic [46:0] p;
		p = 47'(v[23:1]) * 47'(DIV10_MUL);
		return 24'(p[46:26]);
	endfunction

	function automatic logic [3:0] rem10(input logic [23:0] v, input logic [23:0] q);
		logic [23:0] r;
		r = v - q * 24'd10;
		return r[3:0];
	endfunction

	function automatic logic [15:0] div12(input logic [19:0] v);
		logic [36:0] p;
		p = 37'(v[19:2]) * 37'(DIV12_MUL);
		return 16'(p[36:20]);
	endfunction

endpackage
`default_nettype wire

// File: hdl/etd_regs.sv
// APB configuration registers: alarm threshold and trigger interval.
`default_nettype none
module etd_regs
	import etd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_threshold_mm  <= ALARM_RESET;
			cfg_q.trigger_interval_ms <= INTERVAL_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ALARM:    cfg_q.alarm_threshold_mm  <= pwdata[15:0];
				REG_INTERVAL: cfg_q.trigger_interval_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ALARM:    prdata = {16'b0, cfg_q.alarm_threshold_mm};
			REG_INTERVAL: prdata = {16'b0, cfg_q.trigger_interval_ms};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/echo_to_distance_display.sv
// Echo distance display: request pipeline from echo width to buzzer and display digits.
//
// Input requests carry action, now_ms, echo_ready and echo_cycles on a valid/ready
// channel; each request yields exactly one result on the output valid/ready channel.
// A toggle request flips between millimetre and feet:inches display. A tick request
// raises start_reading once trigger_interval_ms has elapsed since the last trigger
// (wrapping 32-bit time) and, with echo_ready, converts the echo into a distance,
// updates the buzzer level and shows four digits.
// The work runs through an eight-register pipeline: the input register, three
// conversion stages (partial products, divide by 500, divide by 10 and by 254),
// three digit stages and the output register. One request per cycle is sustained
// while the receiver takes every result.
// When the receiver stalls, results stop in the output register and earlier stages
// keep filling any empty slots; in_ready drops once every stage is occupied.
// Reset empties the pipeline, clears the last trigger time, selects millimetres,
// turns the buzzer off and loads threshold 475 mm and interval 500 ms.
// Registers are written over APB at byte addresses 0 (threshold) and 4 (interval).
// The user writes them only while no request is in flight; the block does not enforce it.
`default_nettype none
module echo_to_distance_display
	import etd_pkg::*;
#(
	parameter int unsigned ECHO_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [31:0]           now_ms,
	input  wire logic                  echo_ready,
	input  wire logic [ECHO_BITS-1:0]  echo_cycles,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       start_reading,
	output logic                       display_valid,
	output logic                       buzzer_on,
	output logic      [3:0]            digit_ones,
	output logic      [3:0]            digit_tens,
	output logic      [3:0]            digit_hundreds,
	output logic      [3:0]            digit_thousands,
	output logic                       colon_lit
);

	cfg_t cfg;

	etd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Flow control: a stage can load when it is empty or its contents move on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	assign rdy_s8 = !v_s8 || out_ready;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// Input register.
	logic        action_s1;
	logic [31:0] now_s1;
	logic        echo_ready_s1;
	logic [31:0] cycles_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			action_s1     <= action;
			now_s1        <= now_ms;
			echo_ready_s1 <= echo_ready;
			cycles_s1     <= 32'(echo_cycles);
		end
	end

	// Trigger timing and unit toggle; state changes as the request leaves stage 1.
	logic [31:0] last_trig_q;
	logic        inch_q;
	logic [31:0] elapsed;
	logic        fire;
	logic [27:0] hi_c;
	logic [23:0] y_c;

	assign elapsed = now_s1 - last_trig_q;
	assign fire    = (action_s1 == ACTION_TICK) && (elapsed >= {16'b0, cfg.trigger_interval_ms});

	// 17*c/500 splits as 2228*a + (112*a + 17*b)/500 with c = a*2^16 + b.
	assign hi_c = 28'(cycles_s1[31:16]) * 28'd2228;
	assign y_c  = 24'(cycles_s1[31:16]) * 24'd112 + 24'(cycles_s1[15:0]) * 24'd17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_trig_q <= '0;
			inch_q      <= 1'b0;
		end else if (v_s1 && rdy_s2) begin
			if (action_s1 == ACTION_TOGGLE) begin
				inch_q <= ~inch_q;
			end else if (fire) begin
				last_trig_q <= now_s1;
			end
		end
	end

	ctl_t        ctl_s2;
	logic [27:0] hi_s2;
	logic [23:0] y_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ctl_s2.start <= fire;
			ctl_s2.disp  <= (action_s1 == ACTION_TICK) && echo_ready_s1;
			ctl_s2.inch  <= inch_q;
			hi_s2        <= hi_c;
			y_s2         <= y_c;
		end
	end

	// w = floor(17*c / 500); mm and inches both follow from it exactly.
	logic [44:0] q500_p;
	logic [27:0] w_c;
	ctl_t        ctl_s3;
	logic [27:0] w_s3;

	assign q500_p = 45'(y_s2[23:2]) * 45'(Q500_MUL);
	assign w_c    = hi_s2 + 28'(q500_p[44:29]);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctl_s3 <= ctl_s2;
			w_s3   <= w_c;
		end
	end

	logic [54:0] mm_p;
	logic [54:0] inch_p;
	ctl_t        ctl_s4;
	logic [23:0] mm_s4;
	logic [19:0] inches_s4;

	assign mm_p   = 55'(w_s3[27:1]) * 55'(MM_MUL);
	assign inch_p = 55'(w_s3[27:1]) * 55'(INCH_MUL);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ctl_s4    <= ctl_s3;
			mm_s4     <= mm_p[53:30];
			inches_s4 <= inch_p[53:34];
		end
	end

	// Buzzer level and first digit stage.
	logic        buzz_q;
	logic        below;
	logic [23:0] mm_q10;
	logic [15:0] feet;
	logic [19:0] part_full;
	logic [3:0]  part;
	dig_t        dig_a;
	dig_t        dig_s5;

	assign below     = mm_s4 < {8'b0, cfg.alarm_threshold_mm};
	assign mm_q10    = div10(mm_s4);
	assign feet      = div12(inches_s4);
	assign part_full = inches_s4 - 20'(feet) * 20'd12;
	assign part      = part_full[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buzz_q <= 1'b0;
		end else if (v_s4 && rdy_s5 && ctl_s4.disp) begin
			buzz_q <= below;
		end
	end

	always_comb begin
		dig_a.start = ctl_s4.start;
		dig_a.disp  = ctl_s4.disp;
		dig_a.inch  = ctl_s4.inch;
		dig_a.buzz  = ctl_s4.disp ? below : buzz_q;
		dig_a.d2    = '0;
		dig_a.d3    = '0;
		if (ctl_s4.inch) begin
			dig_a.val = 24'(feet);
			if (part >= 4'd10) begin
				dig_a.d0 = part - 4'd10;
				dig_a.d1 = 4'd1;
			end else begin
				dig_a.d0 = part;
				dig_a.d1 = 4'd0;
			end
		end else begin
			dig_a.val = mm_q10;
			dig_a.d0  = rem10(mm_s4, mm_q10);
			dig_a.d1  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			dig_s5 <= dig_a;
		end
	end

	// Tens of millimetres; in feet mode the value passes through.
	logic [23:0] q_b;
	dig_t        dig_b;
	dig_t        dig_s6;

	assign q_b = div10(dig_s5.val);

	always_comb begin
		dig_b = dig_s5;
		if (!dig_s5.inch) begin
			dig_b.val = q_b;
			dig_b.d1  = rem10(dig_s5.val, q_b);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			dig_s6 <= dig_b;
		end
	end

	logic [23:0] q_c;
	dig_t        dig_c;
	dig_t        dig_s7;

	assign q_c = div10(dig_s6.val);

	always_comb begin
		dig_c     = dig_s6;
		dig_c.val = q_c;
		dig_c.d2  = rem10(dig_s6.val, q_c);
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			dig_s7 <= dig_c;
		end
	end

	// Output register; digits and colon are blank when no display is carried.
	logic [23:0] q_d;
	logic        start_s8, disp_s8, buzz_s8, colon_s8;
	logic [3:0]  d0_s8, d1_s8, d2_s8, d3_s8;

	assign q_d = div10(dig_s7.val);

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			start_s8 <= dig_s7.start;
			disp_s8  <= dig_s7.disp;
			buzz_s8  <= dig_s7.buzz;
			colon_s8 <= dig_s7.disp && dig_s7.inch;
			d0_s8    <= dig_s7.disp ? dig_s7.d0 : 4'd0;
			d1_s8    <= dig_s7.disp ? dig_s7.d1 : 4'd0;
			d2_s8    <= dig_s7.disp ? dig_s7.d2 : 4'd0;
			d3_s8    <= dig_s7.disp ? rem10(dig_s7.val, q_d) : 4'd0;
		end
	end

	assign out_valid       = v_s8;
	assign start_reading   = start_s8;
	assign display_valid   = disp_s8;
	assign buzzer_on       = buzz_s8;
	assign digit_ones      = d0_s8;
	assign digit_tens      = d1_s8;
	assign digit_hundreds  = d2_s8;
	assign digit_thousands = d3_s8;
	assign colon_lit       = colon_s8;

`ifndef SYNTHESIS
	a_colon_needs_display: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && colon_lit |-> display_valid)
		else $error("colon lit without a display update");

	a_blank_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !display_valid |-> digit_ones == 4'd0 && digit_tens == 4'd0 &&
			digit_hundreds == 4'd0 && digit_thousands == 4'd0)
		else $error("digits not blank without a display update");

	a_decimal_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_ones < 4'd10 && digit_tens < 4'd10 &&
			digit_hundreds < 4'd10 && digit_thousands < 4'd10)
		else $error("display digit out of decimal range");

	a_inch_tens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && colon_lit |-> digit_tens < 4'd2)
		else $error("inch tens digit above one");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the echo distance display: prediction, stimulus and checks.
`timescale 1ns / 100ps

module testbench
	import etd_pkg::*;
();

	localparam int CLK_HALF     = 4;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 256;
	localparam int NUM_PHASES   = 6;
	localparam int PIPE_LATENCY = 7;

	typedef struct packed {
		logic        action;
		logic [31:0] now;
		logic        ready;
		logic [23:0] cycles;
	} reading_req_t;

	typedef struct packed {
		logic       start;
		logic       valid;
		logic       buzz;
		logic [3:0] d0;
		logic [3:0] d1;
		logic [3:0] d2;
		logic [3:0] d3;
		logic       colon;
	} display_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACTION_TICK;
	logic [31:0]           now_ms = '0;
	logic                  echo_ready = 1'b0;
	logic [23:0]           echo_cycles = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  start_reading;
	logic                  display_valid;
	logic                  buzzer_on;
	logic [3:0]            digit_ones;
	logic [3:0]            digit_tens;
	logic [3:0]            digit_hundreds;
	logic [3:0]            digit_thousands;
	logic                  colon_lit;

	echo_to_distance_display i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .now_ms(now_ms), .echo_ready(echo_ready),
		.echo_cycles(echo_cycles),
		.out_valid(out_valid), .out_ready(out_ready),
		.start_reading(start_reading), .display_valid(display_valid),
		.buzzer_on(buzzer_on), .digit_ones(digit_ones), .digit_tens(digit_tens),
		.digit_hundreds(digit_hundreds), .digit_thousands(digit_thousands),
		.colon_lit(colon_lit)
	);

	always #CLK_HALF clk = ~clk;

	// Mirror of the block's registers and state.
	logic [15:0] cfg_alarm = ALARM_RESET;
	logic [15:0] cfg_interval = INTERVAL_RESET;
	logic [31:0] last_trigger = '0;
	logic        inch_mode = 1'b0;
	logic        buzz_level = 1'b0;

	reading_req_t pending_reqs[$];
	display_t     expected_displays[$];
	reading_req_t cur_req;

	int mismatch_count = 0;
	int requests_taken = 0;
	int displays_seen = 0;
	int triggers_seen = 0;
	int alarms_seen = 0;
	int settings_used = 1;
	int send_gap = 0;
	int send_calm = 0;
	int recv_stall = 0;
	int recv_calm = 0;
	int idle_cycles = 0;
	logic [31:0] clock_ms = '0;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic display_t predict_display(reading_req_t r);
		display_t    e;
		logic [31:0] elapsed;
		logic [63:0] mm, inches, feet, part;
		e = '0;
		if (r.action == ACTION_TOGGLE) begin
			inch_mode = ~inch_mode;
		end else begin
			elapsed = r.now - last_trigger;
			if (elapsed >= {16'd0, cfg_interval}) begin
				e.start = 1'b1;
				last_trigger = r.now;
			end
			if (r.ready) begin
				mm = (64'(r.cycles) * 64'd34) / 64'd10000;
				buzz_level = (mm < 64'(cfg_alarm));
				e.valid = 1'b1;
				if (!inch_mode) begin
					e.d0 = 4'(mm % 10);
					e.d1 = 4'((mm / 10) % 10);
					e.d2 = 4'((mm / 100) % 10);
					e.d3 = 4'((mm / 1000) % 10);
				end else begin
					inches = (64'(r.cycles) * 64'd17) / 64'd127000;
					feet = inches / 12;
					part = inches % 12;
					e.d0 = 4'(part % 10);
					e.d1 = 4'(part / 10);
					e.d2 = 4'(feet % 10);
					e.d3 = 4'((feet / 10) % 10);
					e.colon = 1'b1;
				end
			end
		end
		e.buzz = buzz_level;
		return e;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic reading_req_t make_req(logic act, logic [31:0] t, logic rdy,
			logic [23:0] cyc);
		reading_req_t r;
		r.action = act;
		r.now = t;
		r.ready = rdy;
		r.cycles = cyc;
		return r;
	endfunction

	function automatic reading_req_t next_reading();
		reading_req_t r;
		int           sel;
		longint       base;
		r.action = ($urandom_range(0, 99) < 15) ? ACTION_TOGGLE : ACTION_TICK;
		r.ready = ($urandom_range(0, 99) < 65);
		sel = $urandom_range(0, 99);
		// Time mostly moves forward around the trigger interval, with jumps and wraps.
		if (sel < 40)
			clock_ms = clock_ms + $urandom_range(0, cfg_interval / 4 + 1);
		else if (sel < 80)
			clock_ms = clock_ms + cfg_interval + $urandom_range(0, 4) - 2;
		else if (sel < 92)
			clock_ms = clock_ms + $urandom_range(0, 70000);
		else if (sel < 96)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
		else
			clock_ms = $urandom;
		r.now = clock_ms;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			r.cycles = 24'($urandom);
		end else if (sel < 60) begin
			r.cycles = 24'($urandom_range(0, 200000));
		end else if (sel < 85) begin
			base = longint'(cfg_alarm) * 10000 / 34 + $urandom_range(0, 600) - 300;
			if (base < 0)
				base = 0;
			if (base > 24'hFF_FFFF)
				base = 24'hFF_FFFF;
			r.cycles = 24'(base);
		end else begin
			r.cycles = 24'($urandom) >> $urandom_range(0, 23);
		end
		return r;
	endfunction

	task automatic apb_access(logic wr, logic idx, logic [31:0] data, output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] alarm, logic [15:0] interval);
		logic [31:0] rd;
		apb_access(1'b1, REG_ALARM, {16'd0, alarm}, rd);
		apb_access(1'b1, REG_INTERVAL, {16'd0, interval}, rd);
		cfg_alarm = alarm;
		cfg_interval = interval;
		apb_access(1'b0, REG_ALARM, '0, rd);
		if (rd[15:0] !== alarm)
			report_mismatch("alarm threshold readback", rd[15:0], alarm);
		apb_access(1'b0, REG_INTERVAL, '0, rd);
		if (rd[15:0] !== interval)
			report_mismatch("trigger interval readback", rd[15:0], interval);
		settings_used++;
	endtask

	// Registers may only change with no request in flight.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_displays.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 1) @(negedge clk);
	endtask

	always @(posedge clk) begin : drive_requests
		logic next_valid;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_displays.push_back(predict_display(cur_req));
				requests_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					action <= cur_req.action;
					now_ms <= cur_req.now;
					echo_ready <= cur_req.ready;
					echo_cycles <= cur_req.cycles;
					next_valid = 1'b1;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						if ($urandom_range(0, 49) == 0)
							send_calm = $urandom_range(20, 80);
						send_gap = ($urandom_range(0, 2) == 0) ? 0 : gap_length();
					end
				end
			end
		end
		in_valid <= next_valid;
	end

	always @(posedge clk) begin : check_results
		display_t got, want;
		logic     next_ready;
		if (arst_n && out_valid && out_ready) begin
			got = {start_reading, display_valid, buzzer_on, digit_ones, digit_tens,
				digit_hundreds, digit_thousands, colon_lit};
			if (expected_displays.size() == 0) begin
				report_mismatch("result with no request outstanding", 1, 0);
			end else begin
				want = expected_displays.pop_front();
				if (got.start !== want.start)
					report_mismatch("start_reading", got.start, want.start);
				if (got.valid !== want.valid)
					report_mismatch("display_valid", got.valid, want.valid);
				if (got.buzz !== want.buzz)
					report_mismatch("buzzer_on", got.buzz, want.buzz);
				if (got.d0 !== want.d0)
					report_mismatch("digit_ones", got.d0, want.d0);
				if (got.d1 !== want.d1)
					report_mismatch("digit_tens", got.d1, want.d1);
				if (got.d2 !== want.d2)
					report_mismatch("digit_hundreds", got.d2, want.d2);
				if (got.d3 !== want.d3)
					report_mismatch("digit_thousands", got.d3, want.d3);
				if (got.colon !== want.colon)
					report_mismatch("colon_lit", got.colon, want.colon);
				displays_seen += want.valid;
				triggers_seen += want.start;
				alarms_seen += (want.valid && want.buzz);
			end
		end
		next_ready = 1'b0;
		if (arst_n) begin
			if (recv_stall > 0) begin
				recv_stall--;
			end else begin
				next_ready = 1'b1;
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 49) == 0)
					recv_calm = $urandom_range(20, 80);
				else if ($urandom_range(0, 3) == 0)
					recv_stall = gap_length();
			end
		end
		out_ready <= next_ready;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at the reset settings (threshold 475 mm, interval 500 ms).
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd0, 1'b0, 24'd0));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd499, 1'b1, 24'd0));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd500, 1'b1, 24'hFF_FFFF));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd600, 1'b1, 24'd139706));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd700, 1'b1, 24'd139705));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd999, 1'b1, 24'd10000));
		pending_reqs.push_back(make_req(ACTION_TOGGLE, 32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd1000, 1'b1, 24'hFF_FFFF));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd1001, 1'b1, 24'd82177));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd1002, 1'b1, 24'd82176));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd1003, 1'b1, 24'd0));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'hFFFF_FF00, 1'b0, 24'hAA_AAAA));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'h0000_00F3, 1'b1, 24'h55_5555));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'h0000_00F4, 1'b1, 24'd1000000));
		pending_reqs.push_back(make_req(ACTION_TOGGLE, 32'd0, 1'b0, 24'd0));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd5000, 1'b1, 24'd3000000));
		pending_reqs.push_back(make_req(ACTION_TICK, 32'd5000, 1'b1, 24'd294118));
		clock_ms = 32'd5000;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: set_config(16'd0, 16'd0);
				1: set_config(16'hFFFF, 16'hFFFF);
				2: set_config(16'($urandom), 16'($urandom_range(0, 50)));
				3: set_config(ALARM_RESET, INTERVAL_RESET);
				4: set_config(16'($urandom_range(0, 2000)), 16'($urandom));
				default: set_config(16'($urandom), 16'($urandom));
			endcase
			@(negedge clk);
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_reqs.push_back(next_reading());
		end

		wait_drained();
		repeat (2 * PIPE_LATENCY) @(negedge clk);
		while (expected_displays.size() != 0) begin
			report_mismatch("results never delivered", 0, expected_displays.size());
			void'(expected_displays.pop_front());
		end

		$display("Ran %0d requests over %0d register settings, both display units.",
			requests_taken, settings_used);
		$display("Saw %0d displays, %0d reading triggers and %0d alarms; %0d mismatches.",
			displays_seen, triggers_seen, alarms_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
